// ===== rtl/spq_pkg.sv =====
// shared types and constants for the sorted priority queue
package spq_pkg;

    localparam int DEPTH_DEF = 8;

    localparam int DATA_W = 32;
    localparam int PRIO_W = 16;
    localparam int STATUS_W = 2;
    localparam int OCC_W = 4;

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    localparam logic [STATUS_W-1:0] STAT_OK = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_OVERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_UNDERFLOW = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    typedef struct packed {
        logic capture;
        logic execute;
    } cmd_t;

endpackage

// ===== rtl/sorted_priority_queue.sv =====
// sorted priority queue top level: controller plus sorted-cell datapath
// an accepted item is captured in IDLE and executed in EXEC once the output register is free; the result is registered
// the input side stays stalled in EXEC, so a new item is not taken until the last one has executed
// the input side reopens while a finished result still waits in the output register
// reset clears entry count, controller state and output valid; entry cells are not reset
module sorted_priority_queue #(
    parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              operation,
    input  logic signed [spq_pkg::DATA_W-1:0] item_data,
    input  logic [spq_pkg::PRIO_W-1:0]        item_priority,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [spq_pkg::STATUS_W-1:0]      status,
    output logic signed [spq_pkg::DATA_W-1:0] out_data,
    output logic [spq_pkg::PRIO_W-1:0]        out_priority,
    output logic [spq_pkg::OCC_W-1:0]         occupancy
);

    spq_pkg::cmd_t cmd;

    spq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    spq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .operation     (operation),
        .item_data     (item_data),
        .item_priority (item_priority),
        .status        (status),
        .out_data      (out_data),
        .out_priority  (out_priority),
        .occupancy     (occupancy)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not held off after item accepted");

    a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == spq_pkg::STAT_UNDERFLOW) |->
        (occupancy == '0 && out_data == '0 && out_priority == '0))
        else $error("underflow result with nonzero fields");

    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == spq_pkg::STAT_OVERFLOW) |->
        (occupancy == spq_pkg::OCC_W'(DEPTH) && out_data == '0))
        else $error("overflow result while queue not full");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (DEPTH > 15 || occupancy <= spq_pkg::OCC_W'(DEPTH)))
        else $error("occupancy above depth");

endmodule

// ===== rtl/spq_ctrl.sv =====
// controller state machine: item capture, execute and output handshake
module spq_ctrl (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    output logic         out_valid,
    input  logic         out_stall,
    output spq_pkg::cmd_t cmd
);

    spq_pkg::state_t state_reg;
    spq_pkg::state_t state_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        in_stall = 1'b1;
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        unique case (state_reg)
            spq_pkg::S_IDLE:
            begin
                in_stall = 1'b0;
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    state_next = spq_pkg::S_EXEC;
                end
            end
            spq_pkg::S_EXEC:
            begin
                cmd.execute = out_free;
                if (out_free)
                begin
                    state_next = spq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = spq_pkg::S_IDLE;
            end
        endcase
    end

    assign out_valid_next = cmd.execute || (out_valid_reg && out_stall);
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= spq_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/spq_datapath.sv =====
// sorted entry cells, operand capture and result registers
module spq_datapath #(
    parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  spq_pkg::cmd_t                  cmd,
    input  logic                           operation,
    input  logic signed [spq_pkg::DATA_W-1:0] item_data,
    input  logic [spq_pkg::PRIO_W-1:0]     item_priority,
    output logic [spq_pkg::STATUS_W-1:0]   status,
    output logic signed [spq_pkg::DATA_W-1:0] out_data,
    output logic [spq_pkg::PRIO_W-1:0]     out_priority,
    output logic [spq_pkg::OCC_W-1:0]      occupancy
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic                         op_reg;
    logic [spq_pkg::DATA_W-1:0]   din_reg;
    logic [spq_pkg::PRIO_W-1:0]   pin_reg;

    logic [spq_pkg::DATA_W-1:0]   data_reg [DEPTH];
    logic [spq_pkg::PRIO_W-1:0]   prio_reg [DEPTH];
    logic [CNT_W-1:0]             count_reg;
    logic [CNT_W-1:0]             count_next;

    logic [spq_pkg::STATUS_W-1:0] status_reg;
    logic [spq_pkg::STATUS_W-1:0] status_next;
    logic [spq_pkg::DATA_W-1:0]   odata_reg;
    logic [spq_pkg::DATA_W-1:0]   odata_next;
    logic [spq_pkg::PRIO_W-1:0]   oprio_reg;
    logic [spq_pkg::PRIO_W-1:0]   oprio_next;
    logic [spq_pkg::OCC_W-1:0]    occ_reg;

    logic full;
    logic empty;
    logic enq_en;
    logic deq_en;
    logic [DEPTH-1:0] move;

    assign full = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign enq_en = cmd.execute && (op_reg == spq_pkg::OP_ENQ) && !full;
    assign deq_en = cmd.execute && (op_reg == spq_pkg::OP_DEQ) && !empty;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg <= operation;
            din_reg <= item_data;
            pin_reg <= item_priority;
        end
    end

    // empty slots count as lowest priority, so move is 0..0 1..1
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        assign move[i] = (CNT_W'(i) < count_reg) ? (prio_reg[i] < pin_reg) : 1'b1;

        if (i == 0)
        begin : g_head
            always_ff @(posedge clk)
            begin
                if (enq_en && move[i])
                begin
                    data_reg[i] <= din_reg;
                    prio_reg[i] <= pin_reg;
                end
                else if (deq_en)
                begin
                    data_reg[i] <= data_reg[i+1];
                    prio_reg[i] <= prio_reg[i+1];
                end
            end
        end
        else if (i == DEPTH - 1)
        begin : g_tail
            always_ff @(posedge clk)
            begin
                if (enq_en && move[i])
                begin
                    if (!move[i-1])
                    begin
                        data_reg[i] <= din_reg;
                        prio_reg[i] <= pin_reg;
                    end
                    else
                    begin
                        data_reg[i] <= data_reg[i-1];
                        prio_reg[i] <= prio_reg[i-1];
                    end
                end
            end
        end
        else
        begin : g_mid
            always_ff @(posedge clk)
            begin
                if (enq_en && move[i])
                begin
                    if (!move[i-1])
                    begin
                        data_reg[i] <= din_reg;
                        prio_reg[i] <= pin_reg;
                    end
                    else
                    begin
                        data_reg[i] <= data_reg[i-1];
                        prio_reg[i] <= prio_reg[i-1];
                    end
                end
                else if (deq_en)
                begin
                    data_reg[i] <= data_reg[i+1];
                    prio_reg[i] <= prio_reg[i+1];
                end
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        status_next = spq_pkg::STAT_OK;
        odata_next = '0;
        oprio_next = '0;
        if (op_reg == spq_pkg::OP_ENQ)
        begin
            if (full)
            begin
                status_next = spq_pkg::STAT_OVERFLOW;
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
        else
        begin
            if (empty)
            begin
                status_next = spq_pkg::STAT_UNDERFLOW;
            end
            else
            begin
                count_next = count_reg - CNT_W'(1);
                odata_next = data_reg[0];
                oprio_next = prio_reg[0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.execute)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.execute)
        begin
            status_reg <= status_next;
            odata_reg <= odata_next;
            oprio_reg <= oprio_next;
            occ_reg <= spq_pkg::OCC_W'(count_next);
        end
    end

    assign status = status_reg;
    assign out_data = odata_reg;
    assign out_priority = oprio_reg;
    assign occupancy = occ_reg;

endmodule
